[hdl/lsgs_pkg.sv]
// ---------------------------------------------------------------------------
// lsgs_pkg
// Shared constants, codes and control structs of the split statistics core.
// ---------------------------------------------------------------------------
package lsgs_pkg;

  localparam int FEATURES_DEF = 64;
  localparam int MAX_BINS_DEF = 256;

  // Input word field widths
  localparam int FUNC_W = 2;
  localparam int FEAT_W = 6;
  localparam int BIN_IN_W = 8;
  localparam int VAL_W = 32;
  localparam int IN_W = 80;

  // Output word field widths
  localparam int SUM_W = 48;
  localparam int CNT_W = 32;
  localparam int OUT_W = 128;

  // Configuration port
  localparam int NB_REG_W = 9;
  localparam int PADDR_W = 3;
  localparam logic [PADDR_W-1:0] ADDR_NUM_BINS = 3'd0;
  localparam logic [NB_REG_W-1:0] NUM_BINS_RST = 9'd256;

  // Function codes
  localparam logic [FUNC_W-1:0] FUNC_ACC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // latch the input word and set the address counter
    logic clr_start;  // restart the address counter for a clearing pass
    logic step;       // advance the address counter
    logic rd;         // read the histogram entry at the counter
    logic wr;         // write back the updated entry
    logic wr_zero;    // write an empty entry
    logic acc_en;     // add returned entries into the left sums
    logic out_load;   // load the result register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic acc_ok;     // input word is an accumulate that touches an entry
    logic q_ok;       // input word is a query with bins to walk
    logic walk_end;   // counter sits on the last bin of the walk
    logic clr_end;    // counter sits on the last entry of the store
    logic out_busy;   // result register full and not taken this cycle
  } sts_t;

endpackage

[hdl/lsgs_ram.sv]
// ---------------------------------------------------------------------------
// lsgs_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module lsgs_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/lsgs_ctrl.sv]
// ---------------------------------------------------------------------------
// lsgs_ctrl
// Controller: sequences accumulate, query walk and clearing pass.
// ---------------------------------------------------------------------------
module lsgs_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [lsgs_pkg::FUNC_W-1:0] in_func,
  output logic                        in_ready,
  input  lsgs_pkg::sts_t              sts,
  output lsgs_pkg::cmd_t              cmd
);
  import lsgs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ARD  = 3'd1;
  localparam logic [2:0] S_AWB  = 3'd2;
  localparam logic [2:0] S_QRD  = 3'd3;
  localparam logic [2:0] S_QDRN = 3'd4;
  localparam logic [2:0] S_QOUT = 3'd5;
  localparam logic [2:0] S_CLR  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept = in_valid && in_ready;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          priority if (in_func == FUNC_ACC) begin
            state_next = sts.acc_ok ? S_ARD : S_IDLE;
          end else if (in_func == FUNC_QUERY) begin
            state_next = sts.q_ok ? S_QRD : S_QOUT;
          end else if (in_func == FUNC_CLEAR) begin
            cmd.clr_start = 1'b1;
            state_next = S_CLR;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_ARD: begin
        cmd.rd = 1'b1;
        state_next = S_AWB;
      end
      S_AWB: begin
        cmd.wr = 1'b1;
        state_next = S_IDLE;
      end
      S_QRD: begin
        cmd.rd = 1'b1;
        cmd.acc_en = 1'b1;
        cmd.step = 1'b1;
        if (sts.walk_end) begin
          state_next = S_QDRN;
        end
      end
      S_QDRN: begin
        cmd.acc_en = 1'b1;
        state_next = S_QOUT;
      end
      S_QOUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_CLR: begin
        cmd.wr_zero = 1'b1;
        cmd.step = 1'b1;
        if (sts.clr_end) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hdl/lsgs_datapath.sv]
// ---------------------------------------------------------------------------
// lsgs_datapath
// Datapath: histogram memory, address counter, entry update, left sums.
// ---------------------------------------------------------------------------
module lsgs_datapath #(
  parameter int FEATURES = lsgs_pkg::FEATURES_DEF,
  parameter int MAX_BINS = lsgs_pkg::MAX_BINS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [lsgs_pkg::IN_W-1:0]     in_data,
  input  logic [lsgs_pkg::NB_REG_W-1:0] num_bins,
  input  lsgs_pkg::cmd_t                cmd,
  output lsgs_pkg::sts_t                sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lsgs_pkg::OUT_W-1:0]    out_data
);
  import lsgs_pkg::*;

  localparam int BIN_W = $clog2(MAX_BINS);
  localparam int DEPTH = FEATURES * MAX_BINS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int NB_W = $clog2(MAX_BINS + 1);
  localparam int GS_W = SUM_W + BIN_W;
  localparam int CS_W = CNT_W + BIN_W;
  localparam int ENT_W = 2 * SUM_W + CNT_W;

  logic [FUNC_W-1:0]   f_func;
  logic [FEAT_W-1:0]   f_feat;
  logic [BIN_IN_W-1:0] f_bin;
  logic [NB_W-1:0]     nb;
  logic                feat_ok;
  logic                bin_ok;
  logic [NB_W-1:0]     thr;
  logic [ADDR_W-1:0]   base;
  logic [ADDR_W-1:0]   acc_addr;
  logic [ADDR_W-1:0]   end_calc;

  logic [ADDR_W-1:0]       cnt;
  logic [ADDR_W-1:0]       end_addr;
  logic signed [VAL_W-1:0] grad;
  logic signed [VAL_W-1:0] hess;
  logic                    rvalid;
  logic [ENT_W-1:0]        rdata;
  logic [ENT_W-1:0]        wdata;
  logic signed [GS_W-1:0]  gsum;
  logic signed [GS_W-1:0]  hsum;
  logic [CS_W-1:0]         csum;

  logic signed [SUM_W-1:0] e_g;
  logic signed [SUM_W-1:0] e_h;
  logic [CNT_W-1:0]        e_c;
  logic signed [SUM_W:0]   g_add;
  logic signed [SUM_W:0]   h_add;
  logic [CNT_W-1:0]        c_new;

  // Saturate a sum one bit wider than an entry
  function automatic logic [SUM_W-1:0] sat_entry(input logic signed [SUM_W:0] v);
    logic [SUM_W-1:0] r;
    if (v[SUM_W] != v[SUM_W-1]) begin
      r = {v[SUM_W], {(SUM_W-1){~v[SUM_W]}}};
    end else begin
      r = v[SUM_W-1:0];
    end
    return r;
  endfunction

  // Saturate a left sum to the output width
  function automatic logic [SUM_W-1:0] sat_out(input logic signed [GS_W-1:0] v);
    logic [SUM_W-1:0] r;
    if (v[GS_W-1:SUM_W-1] != {(GS_W-SUM_W+1){v[GS_W-1]}}) begin
      r = {v[GS_W-1], {(SUM_W-1){~v[GS_W-1]}}};
    end else begin
      r = v[SUM_W-1:0];
    end
    return r;
  endfunction

  // Decode the input word
  assign f_func = in_data[FUNC_W-1:0];
  assign f_feat = in_data[FUNC_W +: FEAT_W];
  assign f_bin = in_data[FUNC_W+FEAT_W +: BIN_IN_W];
  assign nb = (32'(num_bins) > 32'(MAX_BINS)) ? NB_W'(MAX_BINS) : NB_W'(num_bins);
  assign feat_ok = (32'(f_feat) < 32'(FEATURES));
  assign bin_ok = (32'(f_bin) < 32'(nb));
  assign thr = bin_ok ? NB_W'(f_bin) : NB_W'(32'(nb) - 32'd1);
  assign base = ADDR_W'(32'(f_feat) * 32'(MAX_BINS));
  assign acc_addr = base + ADDR_W'(f_bin);
  assign end_calc = base + ADDR_W'(thr);

  assign sts.acc_ok = feat_ok && bin_ok && (f_func == FUNC_ACC);
  assign sts.q_ok = feat_ok && (nb != '0) && (f_func == FUNC_QUERY);
  assign sts.walk_end = (cnt == end_addr);
  assign sts.clr_end = (cnt == ADDR_W'(DEPTH - 1));
  assign sts.out_busy = out_valid && !out_ready;

  // Latch the operands and drive the address counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.clr_start) begin
      cnt <= '0;
    end else if (cmd.load) begin
      cnt <= (f_func == FUNC_ACC) ? acc_addr : base;
    end else if (cmd.step) begin
      cnt <= cnt + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      end_addr <= end_calc;
      grad <= in_data[FUNC_W+FEAT_W+BIN_IN_W +: VAL_W];
      hess <= in_data[FUNC_W+FEAT_W+BIN_IN_W+VAL_W +: VAL_W];
    end
  end

  // Entry update for an accumulate
  assign e_g = rdata[SUM_W-1:0];
  assign e_h = rdata[SUM_W +: SUM_W];
  assign e_c = rdata[2*SUM_W +: CNT_W];
  assign g_add = {e_g[SUM_W-1], e_g} + (SUM_W+1)'(grad);
  assign h_add = {e_h[SUM_W-1], e_h} + (SUM_W+1)'(hess);
  assign c_new = (e_c == {CNT_W{1'b1}}) ? e_c : e_c + CNT_W'(1);
  assign wdata = cmd.wr_zero ? '0 : {c_new, sat_entry(h_add), sat_entry(g_add)};

  lsgs_ram #(
    .WIDTH(ENT_W),
    .DEPTH(DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (cmd.wr || cmd.wr_zero),
    .waddr(cnt),
    .wdata(wdata),
    .re   (cmd.rd),
    .raddr(cnt),
    .rdata(rdata)
  );

  // Track read data returning from memory
  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= 1'b0;
    end else begin
      rvalid <= cmd.rd;
    end
  end

  // Left sums over the walk, held exact
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      gsum <= '0;
      hsum <= '0;
      csum <= '0;
    end else if (cmd.acc_en && rvalid) begin
      gsum <= gsum + GS_W'(e_g);
      hsum <= hsum + GS_W'(e_h);
      csum <= csum + CS_W'(e_c);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data[SUM_W-1:0] <= sat_out(gsum);
      out_data[SUM_W +: SUM_W] <= sat_out(hsum);
      out_data[2*SUM_W +: CNT_W] <= (csum[CS_W-1:CNT_W] != '0) ? {CNT_W{1'b1}}
                                                                : csum[CNT_W-1:0];
    end
  end

endmodule

[hdl/left_split_gradient_sums_core.sv]
// ---------------------------------------------------------------------------
// left_split_gradient_sums_core
// Per-feature, per-bin gradient/hessian/count histograms with left-sum query.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream s_axis_* carries one word per operation: accumulate a sample
//   into its feature and bin, query the left sums up to a threshold, or clear.
//   Output stream m_axis_* carries one word per query only. APB register num_bins
//   (address 0): the user writes it only while the core is idle; not enforced.
// Timing:
//   One word is processed at a time. An accumulate steps through accept, memory
//   read and write back, a read-modify-write of a single entry.
//   A query reads memory once per bin walked, then loads the result register.
//   A clear writes all FEATURES*MAX_BINS entries, one entry written per cycle.
// Reset:
//   Reset sets num_bins to 256 and starts a clearing pass over every entry,
//   during which s_axis_tready stays low.
// Back-pressure:
//   A result waits in the output register; accumulates keep flowing while it
//   waits, and a further query holds before loading until the word is taken.
// ---------------------------------------------------------------------------
module left_split_gradient_sums_core #(
  parameter int FEATURES = lsgs_pkg::FEATURES_DEF,
  parameter int MAX_BINS = lsgs_pkg::MAX_BINS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // APB configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lsgs_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // Input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // func[1:0], feature_index[7:2], bin_value[15:8], gradient[47:16], hessian[79:48]
  input  logic [lsgs_pkg::IN_W-1:0]    s_axis_tdata,
  // Output stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // left_gradient_sum[47:0], left_hessian_sum[95:48], left_count[127:96]
  output logic [lsgs_pkg::OUT_W-1:0]   m_axis_tdata
);
  import lsgs_pkg::*;

  logic [NB_REG_W-1:0] num_bins;
  cmd_t                cmd;
  sts_t                sts;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_NUM_BINS) ? {{(32-NB_REG_W){1'b0}}, num_bins} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_bins <= NUM_BINS_RST;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_NUM_BINS)) begin
      num_bins <= pwdata[NB_REG_W-1:0];
    end
  end

  lsgs_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_func (s_axis_tdata[FUNC_W-1:0]),
    .in_ready(s_axis_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  lsgs_datapath #(
    .FEATURES(FEATURES),
    .MAX_BINS(MAX_BINS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (s_axis_tdata),
    .num_bins (num_bins),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (m_axis_tdata)
  );

endmodule

[hdl/lsgs_checker.sv]
// ---------------------------------------------------------------------------
// lsgs_checker
// Port-level checks of the split statistics core, bound to the top level.
// ---------------------------------------------------------------------------
module lsgs_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         pready,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [lsgs_pkg::IN_W-1:0]    s_axis_tdata,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [lsgs_pkg::OUT_W-1:0]   m_axis_tdata
);
  import lsgs_pkg::*;

  // Reset starts the clearing pass, so no word is taken next cycle
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !s_axis_tready)
    else $error("input ready right after reset");

  // One word at a time: busy after a query or a clear; an accumulate that
  // touches no entry may return to idle at once
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && (s_axis_tdata[FUNC_W-1:0] == FUNC_QUERY ||
     s_axis_tdata[FUNC_W-1:0] == FUNC_CLEAR))
    |=> !s_axis_tready)
    else $error("input ready while an operation is in progress");

  // Only a query produces a result
  a_no_result_from_acc: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tdata[FUNC_W-1:0] != FUNC_QUERY)
    |=> !$rose(m_axis_tvalid))
    else $error("result appeared after a non-query word");

  // A stalled result holds its word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result dropped or changed while stalled");

  // The configuration port never waits
  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind left_split_gradient_sums_core lsgs_checker u_lsgs_checker (
  .clk          (clk),
  .rst          (rst),
  .pready       (pready),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
